/* hdl/etdm_pkg.sv */
// shared constants and codes for the event time difference matcher
package etdm_pkg;

   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_TIME_BITS   = 48;

   localparam logic CHAN_FIRST  = 1'b0;
   localparam logic CHAN_SECOND = 1'b1;

   localparam logic KIND_DIFF = 1'b0;
   localparam logic KIND_DROP = 1'b1;

endpackage

/* hdl/etdm_ram.sv */
// generic single write port ram with registered read
module etdm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* hdl/etdm_front.sv */
// front end: two-entry beat queue in front of the matcher sequencer
module etdm_front #(
   parameter int TIME_BITS = etdm_pkg::DEF_TIME_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_action,
   input  logic [TIME_BITS-1:0] req_event_time,
   output logic                 item_valid,
   input  logic                 item_pop,
   output logic                 item_action,
   output logic [TIME_BITS-1:0] item_time
);

   logic [1:0]           fill_ff, fill_in;
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   logic                 act_ff  [2];
   logic [TIME_BITS-1:0] time_ff [2];
   logic                 push;
   logic                 pop;

   assign req_stall   = (fill_ff == 2'd2);
   assign push        = req_valid && !req_stall;
   assign item_valid  = (fill_ff != 2'd0);
   assign pop         = item_pop && item_valid;
   assign item_action = act_ff[rd_ptr_ff];
   assign item_time   = time_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         fill_ff   <= fill_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         act_ff[wr_ptr_ff]  <= req_action;
         time_ff[wr_ptr_ff] <= req_event_time;
      end
   end

endmodule

/* hdl/etdm_back.sv */
// back end: stamp queue, matching sequencer and result register
module etdm_back #(
   parameter int QUEUE_DEPTH = etdm_pkg::DEF_QUEUE_DEPTH,
   parameter int TIME_BITS   = etdm_pkg::DEF_TIME_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      nonneg,
   input  logic                      item_valid,
   output logic                      item_pop,
   input  logic                      item_action,
   input  logic [TIME_BITS-1:0]      item_time,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_kind,
   output logic signed [TIME_BITS:0] rsp_time_difference
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int SUM_W = IDX_W + 1;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(QUEUE_DEPTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_CMP  = 2'b10
   } state_type;

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 owner_ff, owner_in;
   logic                 act_ff, act_in;
   logic [TIME_BITS-1:0] time_ff, time_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_kind_ff, rsp_kind_in;
   logic [TIME_BITS:0]   rsp_diff_ff, rsp_diff_in;

   logic                 out_free;
   logic [IDX_W-1:0]     head_next;
   logic [SUM_W-1:0]     tail_sum;
   logic [IDX_W-1:0]     tail;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [TIME_BITS-1:0] wr_data;
   logic [TIME_BITS-1:0] rd_data;
   logic [TIME_BITS-1:0] stamp_s;
   logic [TIME_BITS-1:0] stamp_f;
   logic                 neg;
   logic [TIME_BITS:0]   diff;

   etdm_ram #(
      .WIDTH (TIME_BITS),
      .DEPTH (QUEUE_DEPTH)
   ) u_stamps (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (head_in),
      .rd_data (rd_data)
   );

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign head_next = (head_ff == IDX_LAST) ? '0 : head_ff + 1'b1;
   assign tail_sum  = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign tail      = (tail_sum >= SUM_W'(QUEUE_DEPTH)) ?
                      IDX_W'(tail_sum - SUM_W'(QUEUE_DEPTH)) : IDX_W'(tail_sum);

   // the queued stamp belongs to the other channel than the pending event
   assign stamp_s = (act_ff == etdm_pkg::CHAN_SECOND) ? time_ff : rd_data;
   assign stamp_f = (act_ff == etdm_pkg::CHAN_SECOND) ? rd_data : time_ff;
   assign neg     = stamp_s < stamp_f;
   assign diff    = {1'b0, stamp_s} - {1'b0, stamp_f};

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      count_in     = count_ff;
      owner_in     = owner_ff;
      act_in       = act_ff;
      time_in      = time_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_kind_in  = rsp_kind_ff;
      rsp_diff_in  = rsp_diff_ff;
      item_pop     = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = tail;
      wr_data      = item_time;

      case (state_ff)
         ST_IDLE: begin
            if (item_valid && out_free) begin
               item_pop = 1'b1;
               act_in   = item_action;
               time_in  = item_time;
               if (count_ff == '0 || owner_ff == item_action) begin
                  if (count_ff == CNT_FULL) begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = etdm_pkg::KIND_DROP;
                     rsp_diff_in  = '0;
                  end else begin
                     wr_en    = 1'b1;
                     count_in = count_ff + 1'b1;
                     owner_in = item_action;
                  end
               end else begin
                  state_in = ST_CMP;
               end
            end
         end
         ST_CMP: begin
            if (!nonneg || !neg) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = etdm_pkg::KIND_DIFF;
                  rsp_diff_in  = diff;
                  head_in      = head_next;
                  count_in     = count_ff - 1'b1;
                  state_in     = ST_IDLE;
               end
            end else if (act_ff == etdm_pkg::CHAN_SECOND) begin
               // new second stamp is too early, drop it
               state_in = ST_IDLE;
            end else begin
               head_in  = head_next;
               count_in = count_ff - 1'b1;
               if (count_ff == CNT_W'(1)) begin
                  // no fitting second stamp, keep the first stamp queued
                  wr_en    = 1'b1;
                  wr_addr  = head_next;
                  wr_data  = time_ff;
                  count_in = CNT_W'(1);
                  owner_in = etdm_pkg::CHAN_FIRST;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         owner_ff     <= etdm_pkg::CHAN_FIRST;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         owner_ff     <= owner_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      time_ff     <= time_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_diff_ff <= rsp_diff_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_time_difference = rsp_diff_ff;

endmodule

/* hdl/event_time_difference_matcher.sv */
// top level of the event time difference matcher
//
// req channel: one beat per event, req_action picks the channel (0 first,
// 1 second) and req_event_time carries the stamp in ticks. a beat is taken
// when req_valid is high and req_stall is low; a two-beat queue sits in front.
// rsp channel: rsp_kind 0 carries rsp_time_difference = second minus first
// stamp (signed); rsp_kind 1 flags an event dropped at a full queue.
// csr_write_enable/csr_write_data set nonnegative mode; the user must write
// them only while the block is idle, which the block itself does not enforce.
//
// an event that only queues passes the sequencer in its idle state. a match
// reads the stamp ram, then compares and loads the result. in nonnegative
// mode a first-channel event examines the queued second stamps in turn, one
// ram read per cycle. the output register loads at the end of the compare,
// and a drop flag shows in the cycle after its beat is taken, plus queueing.
// only one queue holds stamps at any time, so one ram serves both.
//
// reset (synchronous, active high) empties both queues and the beat queue,
// clears the output valid flag and selects plain mode. while rsp_stall is
// high the result beat holds; the sequencer then stops before it needs the
// output register and the input queue fills and raises req_stall.
module event_time_difference_matcher #(
   parameter int QUEUE_DEPTH = etdm_pkg::DEF_QUEUE_DEPTH,
   parameter int TIME_BITS   = etdm_pkg::DEF_TIME_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic                      csr_write_data,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_action,
   input  logic [TIME_BITS-1:0]      req_event_time,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_kind,
   output logic signed [TIME_BITS:0] rsp_time_difference
);

   // nonnegative mode register
   logic                 nonneg_ff, nonneg_in;

   // front to back handoff
   logic                 item_valid;
   logic                 item_pop;
   logic                 item_action;
   logic [TIME_BITS-1:0] item_time;

   assign nonneg_in = csr_write_enable ? csr_write_data : nonneg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         nonneg_ff <= 1'b0;
      end else begin
         nonneg_ff <= nonneg_in;
      end
   end

   // accepts beats, lets the back end stall independently
   etdm_front #(
      .TIME_BITS (TIME_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_event_time (req_event_time),
      .item_valid     (item_valid),
      .item_pop       (item_pop),
      .item_action    (item_action),
      .item_time      (item_time)
   );

   // stamp queue, matching and result register
   etdm_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TIME_BITS   (TIME_BITS)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .nonneg              (nonneg_ff),
      .item_valid          (item_valid),
      .item_pop            (item_pop),
      .item_action         (item_action),
      .item_time           (item_time),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_kind            (rsp_kind),
      .rsp_time_difference (rsp_time_difference)
   );

endmodule
